// ----- rtl/polar_pose_controller_defines.svh -----
// Assertion helpers for the RTL.
`ifndef POLAR_POSE_CONTROLLER_DEFINES_SVH
`define POLAR_POSE_CONTROLLER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define PPC_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define PPC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/ppc_pkg.sv -----
package ppc_pkg;

	localparam int POS_W      = 32;
	localparam int DIFF_W     = POS_W + 1;
	localparam int ANG_W      = 16;
	localparam int DANG_W     = ANG_W + 1;
	localparam int WRAP_W     = 19;
	localparam int GAIN_W     = 16;
	localparam int RATE_W     = 16;
	localparam int LIMIT_W    = 31;
	localparam int VEL_W      = 32;
	localparam int WIDE_W     = 48;
	localparam int ACC_W      = 53;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 31;

	localparam int MUL_W  = 34;
	localparam int PROD_W = 2 * MUL_W;

	localparam int CORDIC_STEPS = 16;
	localparam int CORDIC_IW    = $clog2(CORDIC_STEPS);
	localparam int CORDIC_W     = POS_W + 4;
	localparam int ATAN_ENTRIES = 14;
	localparam int ATAN_IW      = 5;

	localparam int SQRT_IN_W  = 2 * POS_W;
	localparam int SQRT_STEPS = POS_W;
	localparam int SQRT_IW    = $clog2(SQRT_STEPS);

	typedef logic signed [DIFF_W-1:0]   diff_t;
	typedef logic signed [ANG_W-1:0]    ang_t;
	typedef logic signed [DANG_W-1:0]   dang_t;
	typedef logic signed [WRAP_W-1:0]   wrap_t;
	typedef logic signed [GAIN_W-1:0]   gain_t;
	typedef logic signed [MUL_W-1:0]    op_t;
	typedef logic signed [PROD_W-1:0]   prod_t;
	typedef logic signed [CORDIC_W-1:0] cw_t;
	typedef logic signed [ACC_W-1:0]    acc_t;
	typedef logic signed [WIDE_W-1:0]   wide_t;
	typedef logic signed [VEL_W-1:0]    vel_t;
	typedef logic [SQRT_IN_W-1:0]       sq_t;
	typedef logic [POS_W-1:0]           dist_t;

	localparam wrap_t ANG_PI      = 19'sd25736;
	localparam wrap_t ANG_TWO_PI  = 19'sd51472;
	localparam ang_t  ANG_HALF_PI = 16'sd12868;
	localparam wrap_t ANG_MAX     = 19'sd32767;
	localparam wrap_t ANG_MIN     = -19'sd32768;
	localparam wide_t VEL_FLOOR   = -48'sd2147483648;

	localparam ang_t ATAN_TABLE [ATAN_ENTRIES] = '{
		16'sd6434, 16'sd3798, 16'sd2007, 16'sd1019, 16'sd511, 16'sd256, 16'sd128,
		16'sd64, 16'sd32, 16'sd16, 16'sd8, 16'sd4, 16'sd2, 16'sd1
	};

	typedef enum logic [3:0] {
		S_IDLE,
		S_SQX,
		S_SQY,
		S_SUM,
		S_ROOT,
		S_ALPHA,
		S_BETA,
		S_PA,
		S_PB,
		S_DA,
		S_DB,
		S_DR,
		S_ACC,
		S_CLAMP
	} state_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LIN_GAIN,
		CFG_HEADING_GAIN,
		CFG_FINAL_ANGLE_GAIN,
		CFG_HEADING_DERIV_GAIN,
		CFG_FINAL_DERIV_GAIN,
		CFG_SAMPLE_RATE,
		CFG_MAX_LINEAR,
		CFG_MAX_ANGULAR
	} cfg_idx_t;

	function automatic ang_t atan_entry(input logic [CORDIC_IW-1:0] i);
		logic [ATAN_IW-1:0] j;
		ang_t v;
		j = ATAN_IW'(i);
		v = '0;
		if (j < ATAN_IW'(ATAN_ENTRIES)) begin
			v = ATAN_TABLE[j[3:0]];
		end
		return v;
	endfunction

	// one step down, then one step up; exactly pi stays pi
	function automatic wrap_t wrap_angle(input wrap_t a);
		wrap_t t;
		t = a;
		if (t >= ANG_PI) begin
			t = t - ANG_TWO_PI;
		end
		if (t <= -ANG_PI) begin
			t = t + ANG_TWO_PI;
		end
		return t;
	endfunction

endpackage

// ----- rtl/ppc_pose_if.sv -----
interface ppc_pose_if;
	logic valid;
	logic ready;
	logic signed [ppc_pkg::POS_W-1:0] cur_x;
	logic signed [ppc_pkg::POS_W-1:0] cur_y;
	logic signed [ppc_pkg::ANG_W-1:0] cur_heading;
	logic signed [ppc_pkg::POS_W-1:0] goal_x;
	logic signed [ppc_pkg::POS_W-1:0] goal_y;
	logic signed [ppc_pkg::ANG_W-1:0] goal_heading;

	modport source (
		output valid, cur_x, cur_y, cur_heading, goal_x, goal_y, goal_heading,
		input ready
	);
	modport sink (
		input valid, cur_x, cur_y, cur_heading, goal_x, goal_y, goal_heading,
		output ready
	);
endinterface

// ----- rtl/ppc_cmd_if.sv -----
interface ppc_cmd_if;
	logic valid;
	logic ready;
	logic [ppc_pkg::POS_W-1:0]        distance;
	logic signed [ppc_pkg::VEL_W-1:0] lin_velocity;
	logic signed [ppc_pkg::VEL_W-1:0] ang_velocity;

	modport source (
		output valid, distance, lin_velocity, ang_velocity,
		input ready
	);
	modport sink (
		input valid, distance, lin_velocity, ang_velocity,
		output ready
	);
endinterface

// ----- rtl/ppc_mul.sv -----
module ppc_mul (
	input  logic           clk,
	input  ppc_pkg::op_t   a,
	input  ppc_pkg::op_t   b,
	output ppc_pkg::prod_t product
);

	ppc_pkg::prod_t prod_q;

	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

	assign product = prod_q;

endmodule

// ----- rtl/ppc_isqrt.sv -----
module ppc_isqrt (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  ppc_pkg::sq_t   radicand,
	output logic           busy,
	output ppc_pkg::dist_t root
);

	logic                        busy_q;
	logic [ppc_pkg::SQRT_IW-1:0] cnt_q;
	ppc_pkg::sq_t                n_q;
	ppc_pkg::sq_t                r_q;
	ppc_pkg::sq_t                b_q;
	ppc_pkg::sq_t                trial;
	logic                        fits;

	assign trial = r_q + b_q;
	assign fits  = n_q >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			if (cnt_q == ppc_pkg::SQRT_IW'(ppc_pkg::SQRT_STEPS - 1)) begin
				busy_q <= 1'b0;
			end
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// two radicand bits consumed and one result bit made per step
	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= radicand;
			r_q <= '0;
			b_q <= ppc_pkg::sq_t'(1) << (ppc_pkg::SQRT_IN_W - 2);
		end else if (busy_q) begin
			if (fits) begin
				n_q <= n_q - trial;
				r_q <= (r_q >> 1) + b_q;
			end else begin
				r_q <= r_q >> 1;
			end
			b_q <= b_q >> 2;
		end
	end

	assign busy = busy_q;
	assign root = r_q[ppc_pkg::POS_W-1:0];

endmodule

// ----- rtl/ppc_cordic.sv -----
module ppc_cordic (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  ppc_pkg::diff_t  dx,
	input  ppc_pkg::diff_t  dy,
	output logic            busy,
	output ppc_pkg::ang_t   theta
);

	logic                          busy_q;
	logic [ppc_pkg::CORDIC_IW-1:0] idx_q;
	ppc_pkg::cw_t                  x_q;
	ppc_pkg::cw_t                  y_q;
	ppc_pkg::ang_t                 z_q;
	logic                          zero_q;

	ppc_pkg::cw_t  x0;
	ppc_pkg::cw_t  y0;
	ppc_pkg::ang_t z0;
	ppc_pkg::cw_t  xs;
	ppc_pkg::cw_t  ys;
	ppc_pkg::ang_t step_ang;
	logic          cw;

	// pre-rotate into the right half plane
	always_comb begin
		x0 = ppc_pkg::cw_t'(dx);
		y0 = ppc_pkg::cw_t'(dy);
		z0 = '0;
		if (dx[ppc_pkg::DIFF_W-1]) begin
			if (!dy[ppc_pkg::DIFF_W-1]) begin
				x0 = ppc_pkg::cw_t'(dy);
				y0 = -ppc_pkg::cw_t'(dx);
				z0 = ppc_pkg::ANG_HALF_PI;
			end else begin
				x0 = -ppc_pkg::cw_t'(dy);
				y0 = ppc_pkg::cw_t'(dx);
				z0 = -ppc_pkg::ANG_HALF_PI;
			end
		end
	end

	always_comb begin
		xs       = x_q >>> idx_q;
		ys       = y_q >>> idx_q;
		step_ang = ppc_pkg::atan_entry(idx_q);
		cw       = !y_q[ppc_pkg::CORDIC_W-1] && (y_q != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (busy_q) begin
			if (idx_q == ppc_pkg::CORDIC_IW'(ppc_pkg::CORDIC_STEPS - 1)) begin
				busy_q <= 1'b0;
			end
			idx_q <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= x0;
			y_q    <= y0;
			z_q    <= z0;
			zero_q <= (dx == '0) && (dy == '0);
		end else if (busy_q) begin
			if (cw) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + step_ang;
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - step_ang;
			end
		end
	end

	assign busy  = busy_q;
	assign theta = zero_q ? '0 : z_q;

endmodule

// ----- rtl/polar_pose_controller.sv -----
// channel | dir | beat carries
// --------+-----+---------------------------------------------------------------
// pose    | in  | cur_x, cur_y, cur_heading, goal_x, goal_y, goal_heading
// cmd     | out | distance, lin_velocity, ang_velocity
// cfg     | in  | cfg_write, cfg_index, cfg_data (write only, one cycle)
//
// One pose beat at a time. The 32-step square root unit runs alongside the
// 16-step CORDIC, which finishes first, and the square root ends the wait.
// Products go through one shared 34x34 multiplier, one per cycle.
// pose.ready is high only while idle; a result waiting in the cmd register does not
// block the next accept, but a stalled cmd side holds the block before its next load.
// arst_n clears control, gains to reset values and the previous errors to zero.
`include "polar_pose_controller_defines.svh"

module polar_pose_controller (
	input  logic                              clk,
	input  logic                              arst_n,
	ppc_pose_if.sink                          pose,
	ppc_cmd_if.source                         cmd,
	input  logic                              cfg_write,
	input  logic [ppc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ppc_pkg::CFG_DATA_W-1:0]    cfg_data
);

	ppc_pkg::state_t state_q;
	ppc_pkg::state_t state_d;

	ppc_pkg::gain_t              lin_gain_q;
	ppc_pkg::gain_t              heading_gain_q;
	ppc_pkg::gain_t              final_angle_gain_q;
	ppc_pkg::gain_t              heading_deriv_gain_q;
	ppc_pkg::gain_t              final_deriv_gain_q;
	logic [ppc_pkg::RATE_W-1:0]  sample_rate_q;
	logic [ppc_pkg::LIMIT_W-1:0] max_linear_q;
	logic [ppc_pkg::LIMIT_W-1:0] max_angular_q;

	ppc_pkg::diff_t dx_q;
	ppc_pkg::diff_t dy_q;
	ppc_pkg::ang_t  ch_q;
	ppc_pkg::ang_t  gh_q;
	ppc_pkg::dist_t abs_dx;
	ppc_pkg::dist_t abs_dy;

	ppc_pkg::op_t   mul_a;
	ppc_pkg::op_t   mul_b;
	ppc_pkg::prod_t product;

	ppc_pkg::sq_t                 sx2_q;
	logic [ppc_pkg::SQRT_IN_W:0]  sq_sum;
	logic                         sat_q;
	ppc_pkg::dist_t               rho_q;

	logic           cordic_start;
	logic           cordic_busy;
	ppc_pkg::ang_t  theta;
	logic           sqrt_start;
	logic           sqrt_busy;
	ppc_pkg::dist_t root;

	ppc_pkg::wrap_t alpha_wrap;
	ppc_pkg::wrap_t beta_wrap;
	ppc_pkg::ang_t  beta_sat;
	ppc_pkg::ang_t  alpha_q;
	ppc_pkg::ang_t  beta_q;
	ppc_pkg::ang_t  prev_alpha_q;
	ppc_pkg::ang_t  prev_beta_q;
	ppc_pkg::dang_t d_alpha;
	ppc_pkg::dang_t d_beta;

	ppc_pkg::wide_t lin_full;
	ppc_pkg::vel_t  lin_clamped;
	ppc_pkg::vel_t  lin_q;
	ppc_pkg::acc_t  acc_q;
	ppc_pkg::op_t   dsum_q;
	ppc_pkg::wide_t ang_full;
	ppc_pkg::wide_t ang_lim;
	ppc_pkg::vel_t  ang_clamped;

	logic           out_valid_q;
	logic           out_free;
	logic           load_out;
	ppc_pkg::dist_t dist_q;
	ppc_pkg::vel_t  lin_out_q;
	ppc_pkg::vel_t  ang_out_q;

	ppc_mul u_mul (
		.clk     (clk),
		.a       (mul_a),
		.b       (mul_b),
		.product (product)
	);

	ppc_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cordic_start),
		.dx     (dx_q),
		.dy     (dy_q),
		.busy   (cordic_busy),
		.theta  (theta)
	);

	ppc_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (sq_sum[ppc_pkg::SQRT_IN_W-1:0]),
		.busy     (sqrt_busy),
		.root     (root)
	);

	// datapath arithmetic
	always_comb begin
		abs_dx = dx_q[ppc_pkg::DIFF_W-1] ? ppc_pkg::dist_t'(-dx_q) : dx_q[ppc_pkg::POS_W-1:0];
		abs_dy = dy_q[ppc_pkg::DIFF_W-1] ? ppc_pkg::dist_t'(-dy_q) : dy_q[ppc_pkg::POS_W-1:0];
		sq_sum = {1'b0, sx2_q} + {1'b0, ppc_pkg::sq_t'(product)};

		alpha_wrap = ppc_pkg::wrap_angle(ppc_pkg::wrap_t'(theta) - ppc_pkg::wrap_t'(ch_q));
		beta_wrap  = ppc_pkg::wrap_angle(-ppc_pkg::wrap_t'(ch_q) - ppc_pkg::wrap_t'(alpha_q)
			- ppc_pkg::wrap_t'(gh_q));
		if (beta_wrap > ppc_pkg::ANG_MAX) begin
			beta_sat = ppc_pkg::ang_t'(ppc_pkg::ANG_MAX);
		end else if (beta_wrap < ppc_pkg::ANG_MIN) begin
			beta_sat = ppc_pkg::ang_t'(ppc_pkg::ANG_MIN);
		end else begin
			beta_sat = ppc_pkg::ang_t'(beta_wrap);
		end

		d_alpha = ppc_pkg::dang_t'(alpha_q) - ppc_pkg::dang_t'(prev_alpha_q);
		d_beta  = ppc_pkg::dang_t'(beta_q) - ppc_pkg::dang_t'(prev_beta_q);

		lin_full = ppc_pkg::wide_t'(product >>> 8);
		if (lin_full > ppc_pkg::wide_t'(max_linear_q)) begin
			lin_clamped = ppc_pkg::vel_t'(max_linear_q);
		end else if (lin_full < ppc_pkg::VEL_FLOOR) begin
			lin_clamped = ppc_pkg::vel_t'(ppc_pkg::VEL_FLOOR);
		end else begin
			lin_clamped = ppc_pkg::vel_t'(lin_full);
		end

		ang_full = ppc_pkg::wide_t'(acc_q >>> 5);
		ang_lim  = ppc_pkg::wide_t'(max_angular_q);
		if (ang_full > ang_lim) begin
			ang_clamped = ppc_pkg::vel_t'(ang_lim);
		end else if (ang_full < -ang_lim) begin
			ang_clamped = ppc_pkg::vel_t'(-ang_lim);
		end else begin
			ang_clamped = ppc_pkg::vel_t'(ang_full);
		end
	end

	assign out_free = !out_valid_q || cmd.ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ppc_pkg::S_IDLE: begin
				if (pose.valid) begin
					state_d = ppc_pkg::S_SQX;
				end
			end
			ppc_pkg::S_SQX:   state_d = ppc_pkg::S_SQY;
			ppc_pkg::S_SQY:   state_d = ppc_pkg::S_SUM;
			ppc_pkg::S_SUM:   state_d = ppc_pkg::S_ROOT;
			ppc_pkg::S_ROOT: begin
				if (!sqrt_busy && !cordic_busy) begin
					state_d = ppc_pkg::S_ALPHA;
				end
			end
			ppc_pkg::S_ALPHA: state_d = ppc_pkg::S_BETA;
			ppc_pkg::S_BETA:  state_d = ppc_pkg::S_PA;
			ppc_pkg::S_PA:    state_d = ppc_pkg::S_PB;
			ppc_pkg::S_PB:    state_d = ppc_pkg::S_DA;
			ppc_pkg::S_DA:    state_d = ppc_pkg::S_DB;
			ppc_pkg::S_DB:    state_d = ppc_pkg::S_DR;
			ppc_pkg::S_DR:    state_d = ppc_pkg::S_ACC;
			ppc_pkg::S_ACC:   state_d = ppc_pkg::S_CLAMP;
			ppc_pkg::S_CLAMP: begin
				if (out_free) begin
					state_d = ppc_pkg::S_IDLE;
				end
			end
			default:          state_d = ppc_pkg::S_IDLE;
		endcase
	end

	// sequencer outputs and multiplier operand select
	always_comb begin
		pose.ready   = 1'b0;
		cordic_start = 1'b0;
		sqrt_start   = 1'b0;
		load_out     = 1'b0;
		mul_a        = '0;
		mul_b        = '0;
		unique case (state_q)
			ppc_pkg::S_IDLE:  pose.ready = 1'b1;
			ppc_pkg::S_SQX: begin
				cordic_start = 1'b1;
				mul_a        = ppc_pkg::op_t'(abs_dx);
				mul_b        = ppc_pkg::op_t'(abs_dx);
			end
			ppc_pkg::S_SQY: begin
				mul_a = ppc_pkg::op_t'(abs_dy);
				mul_b = ppc_pkg::op_t'(abs_dy);
			end
			ppc_pkg::S_SUM:   sqrt_start = 1'b1;
			ppc_pkg::S_ALPHA: begin
				mul_a = ppc_pkg::op_t'(rho_q);
				mul_b = ppc_pkg::op_t'(lin_gain_q);
			end
			ppc_pkg::S_BETA: begin
				mul_a = ppc_pkg::op_t'(heading_gain_q);
				mul_b = ppc_pkg::op_t'(alpha_q);
			end
			ppc_pkg::S_PA: begin
				mul_a = ppc_pkg::op_t'(final_angle_gain_q);
				mul_b = ppc_pkg::op_t'(beta_q);
			end
			ppc_pkg::S_PB: begin
				mul_a = ppc_pkg::op_t'(heading_deriv_gain_q);
				mul_b = ppc_pkg::op_t'(d_alpha);
			end
			ppc_pkg::S_DA: begin
				mul_a = ppc_pkg::op_t'(final_deriv_gain_q);
				mul_b = ppc_pkg::op_t'(d_beta);
			end
			ppc_pkg::S_DR: begin
				mul_a = dsum_q;
				mul_b = ppc_pkg::op_t'(sample_rate_q);
			end
			ppc_pkg::S_CLAMP: load_out = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ppc_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lin_gain_q           <= 16'sd256;
			heading_gain_q       <= 16'sd256;
			final_angle_gain_q   <= '0;
			heading_deriv_gain_q <= '0;
			final_deriv_gain_q   <= '0;
			sample_rate_q        <= 16'd100;
			max_linear_q         <= 31'd32768;
			max_angular_q        <= 31'd65536;
		end else if (cfg_write) begin
			unique case (ppc_pkg::cfg_idx_t'(cfg_index))
				ppc_pkg::CFG_LIN_GAIN:
					lin_gain_q <= ppc_pkg::gain_t'(cfg_data[ppc_pkg::GAIN_W-1:0]);
				ppc_pkg::CFG_HEADING_GAIN:
					heading_gain_q <= ppc_pkg::gain_t'(cfg_data[ppc_pkg::GAIN_W-1:0]);
				ppc_pkg::CFG_FINAL_ANGLE_GAIN:
					final_angle_gain_q <= ppc_pkg::gain_t'(cfg_data[ppc_pkg::GAIN_W-1:0]);
				ppc_pkg::CFG_HEADING_DERIV_GAIN:
					heading_deriv_gain_q <= ppc_pkg::gain_t'(cfg_data[ppc_pkg::GAIN_W-1:0]);
				ppc_pkg::CFG_FINAL_DERIV_GAIN:
					final_deriv_gain_q <= ppc_pkg::gain_t'(cfg_data[ppc_pkg::GAIN_W-1:0]);
				ppc_pkg::CFG_SAMPLE_RATE:
					sample_rate_q <= cfg_data[ppc_pkg::RATE_W-1:0];
				ppc_pkg::CFG_MAX_LINEAR:
					max_linear_q <= cfg_data[ppc_pkg::LIMIT_W-1:0];
				ppc_pkg::CFG_MAX_ANGULAR:
					max_angular_q <= cfg_data[ppc_pkg::LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_alpha_q <= '0;
			prev_beta_q  <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (load_out) begin
				prev_alpha_q <= alpha_q;
				prev_beta_q  <= beta_q;
				out_valid_q  <= 1'b1;
			end else if (cmd.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ppc_pkg::S_IDLE: begin
				if (pose.valid) begin
					dx_q <= ppc_pkg::diff_t'(pose.goal_x) - ppc_pkg::diff_t'(pose.cur_x);
					dy_q <= ppc_pkg::diff_t'(pose.goal_y) - ppc_pkg::diff_t'(pose.cur_y);
					ch_q <= pose.cur_heading;
					gh_q <= pose.goal_heading;
				end
			end
			ppc_pkg::S_SQY:   sx2_q <= ppc_pkg::sq_t'(product);
			ppc_pkg::S_SUM:   sat_q <= sq_sum[ppc_pkg::SQRT_IN_W];
			ppc_pkg::S_ROOT:  rho_q <= sat_q ? '1 : root;
			ppc_pkg::S_ALPHA: alpha_q <= ppc_pkg::ang_t'(alpha_wrap);
			ppc_pkg::S_BETA: begin
				beta_q <= beta_sat;
				lin_q  <= lin_clamped;
			end
			ppc_pkg::S_PA:    acc_q <= ppc_pkg::acc_t'(product);
			ppc_pkg::S_PB:    acc_q <= acc_q + ppc_pkg::acc_t'(product);
			ppc_pkg::S_DA:    dsum_q <= ppc_pkg::op_t'(product);
			ppc_pkg::S_DB:    dsum_q <= dsum_q + ppc_pkg::op_t'(product);
			ppc_pkg::S_ACC:   acc_q <= acc_q + ppc_pkg::acc_t'(product);
			ppc_pkg::S_CLAMP: begin
				if (load_out) begin
					dist_q    <= rho_q;
					lin_out_q <= lin_q;
					ang_out_q <= ang_clamped;
				end
			end
			default: ;
		endcase
	end

	assign cmd.valid        = out_valid_q;
	assign cmd.distance     = dist_q;
	assign cmd.lin_velocity = lin_out_q;
	assign cmd.ang_velocity = ang_out_q;

	`PPC_ASSERT_SAME(a_cordic_first, (state_q == ppc_pkg::S_ROOT) && !sqrt_busy,
		!cordic_busy, "bearing not settled when root done")
	`PPC_ASSERT_NEXT(a_load_shows, (state_q == ppc_pkg::S_CLAMP) && out_free,
		cmd.valid && (state_q == ppc_pkg::S_IDLE), "result load missed")
	`PPC_ASSERT_NEXT(a_prev_hold, state_q != ppc_pkg::S_CLAMP,
		$stable(prev_alpha_q) && $stable(prev_beta_q), "previous errors changed outside load")

endmodule
